// ===== design/sensor_register_access_framer_top_assert.svh =====
// Assertion macros for the sensor register access framer checker.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef SENSOR_REGISTER_ACCESS_FRAMER_TOP_ASSERT_SVH
`define SENSOR_REGISTER_ACCESS_FRAMER_TOP_ASSERT_SVH

// Checked on every rising edge outside reset.
`define SRAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SRAF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/sraf_pkg.sv =====
// Shared types, codes and constants of the sensor register access framer.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package sraf_pkg;

  localparam int MaxBytes  = 16;
  localparam int CntW      = 5;
  localparam int BufIdxW   = $clog2(MaxBytes);
  localparam int InTdataW  = 32;
  localparam int OutTdataW = 144;

  localparam logic [7:0]  OpRamRead    = 8'h20;
  localparam logic [7:0]  OpEepRead    = 8'h40;
  localparam logic [7:0]  OpRamWrite   = 8'h10;
  localparam logic [7:0]  OpEepWrite   = 8'h30;
  localparam logic [7:0]  CountMask    = 8'b0000_1111;
  localparam logic [15:0] TimeoutReset = 16'd1000;
  localparam logic [15:0] ElapsedMax   = 16'hFFFF;
  localparam logic [31:0] CounterMax   = 32'hFFFF_FFFF;

  localparam logic [1:0] CntOk       = 2'd0;
  localparam logic [1:0] CntTimeout  = 2'd1;
  localparam logic [1:0] CntCmdFail  = 2'd2;
  localparam logic [1:0] CntSumFail  = 2'd3;

  typedef enum logic [2:0] {
    MODE_OPEN_RD = 3'd0,
    MODE_OPEN_WR = 3'd1,
    MODE_PAYLOAD = 3'd2,
    MODE_RESP    = 3'd3,
    MODE_TICK    = 3'd4,
    MODE_CLEAR   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    KIND_SEND   = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_COUNT = 3'd1,
    ST_TIMEOUT   = 3'd2,
    ST_CMD_FAIL  = 3'd3,
    ST_SUM_FAIL  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PAYLOAD,
    PH_RESP_READ,
    PH_RESP_WRITE
  } phase_e;

  // Which run of results the last executed item produces.
  typedef enum logic [2:0] {
    PL_INVALID,
    PL_OPEN_RD,
    PL_OPEN_WR,
    PL_PAY_MID,
    PL_PAY_END,
    PL_FIN_RD,
    PL_FIN_WR
  } plan_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EXEC,
    CS_EMIT
  } ctl_state_e;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic has_results;
    logic out_free;
    logic emit_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/sraf_ctrl.sv =====
// Controller state machine of the sensor register access framer.
// Depends on sraf_pkg; drives the datapath through dp_cmd_t.
`default_nettype none

module sraf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sraf_pkg::dp_stat_t stat_i,
  output sraf_pkg::dp_cmd_t  cmd_o
);

  sraf_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sraf_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      sraf_pkg::CS_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
        if (in_valid_i) begin
          state_d = sraf_pkg::CS_EXEC;
        end
      end
      sraf_pkg::CS_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.has_results ? sraf_pkg::CS_EMIT : sraf_pkg::CS_IDLE;
      end
      sraf_pkg::CS_EMIT: begin
        cmd_o.emit = stat_i.out_free;
        if (stat_i.out_free && stat_i.emit_last) begin
          state_d = sraf_pkg::CS_IDLE;
        end
      end
      default: begin
        state_d = sraf_pkg::CS_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/sraf_datapath.sv =====
// Datapath of the sensor register access framer: item register, protocol
// state, read buffer, event counters and output register. Depends on sraf_pkg.
`default_nettype none

module sraf_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sraf_pkg::dp_cmd_t                   cmd_i,
  output sraf_pkg::dp_stat_t                  stat_o,
  input  logic [sraf_pkg::InTdataW-1:0]       in_data_i,
  input  logic [2:0]                          in_user_i,
  input  logic                                cfg_valid_i,
  input  logic [15:0]                         cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sraf_pkg::OutTdataW-1:0]      out_data_o,
  output logic [1:0]                          out_user_o,
  output logic                                out_last_o
);

  // Latched input item.
  logic [2:0]                    it_mode_q;
  logic                          it_eep_q;
  logic [sraf_pkg::CntW-1:0]     it_cnt_q;
  logic [15:0]                   it_addr_q;
  logic                          it_swp_q;
  logic [7:0]                    it_db_q;

  // Protocol state.
  logic [15:0]                   timeout_q;
  sraf_pkg::phase_e              phase_q, phase_d;
  logic [sraf_pkg::CntW-1:0]     len_q, len_d;
  logic [sraf_pkg::CntW-1:0]     pos_q, pos_d;
  logic [7:0]                    sum_q, sum_d;
  logic [7:0]                    first_q, first_d;
  logic                          rev_q, rev_d;
  logic [15:0]                   elapsed_q, elapsed_d;
  logic [7:0]                    buf_q [sraf_pkg::MaxBytes];
  logic [31:0]                   cnt_q [4];

  // Result run bookkeeping.
  sraf_pkg::plan_e               plan_q, plan_d;
  logic [sraf_pkg::CntW-1:0]     res_n_q, res_n_d;
  logic [sraf_pkg::CntW-1:0]     idx_q;
  sraf_pkg::status_e             st_q, st_d;
  logic [7:0]                    cmd_byte_q, cmd_byte_d;

  // Output register.
  logic                          out_valid_q;
  sraf_pkg::kind_e               out_kind_q;
  logic [7:0]                    out_byte_q;
  sraf_pkg::status_e             out_st_q;
  logic                          out_last_q;
  logic [31:0]                   out_cnt_q [4];

  // Execute-step signals.
  logic                          run;
  logic                          buf_we;
  logic [sraf_pkg::BufIdxW-1:0]  buf_waddr;
  logic                          bump_en;
  logic [1:0]                    bump_idx;
  logic                          clr;
  logic                          count_ok;
  logic                          is_rd;
  logic [7:0]                    op_base;
  logic [7:0]                    open_cmd;
  logic [7:0]                    open_sum;
  logic [sraf_pkg::CntW-1:0]     pos_inc;
  sraf_pkg::status_e             rd_st;
  sraf_pkg::status_e             wr_st;

  // Emit-step signals.
  logic [sraf_pkg::CntW-1:0]     src_full;
  logic [sraf_pkg::BufIdxW-1:0]  src;
  logic                          emit_last;
  sraf_pkg::kind_e               e_kind;
  logic [7:0]                    e_byte;
  sraf_pkg::status_e             e_st;

  function automatic sraf_pkg::status_e judge(input logic [15:0] elapsed,
                                              input logic [15:0] limit,
                                              input logic        cmd_ok,
                                              input logic        sum_ok);
    sraf_pkg::status_e r;
    if (elapsed > limit) begin
      r = sraf_pkg::ST_TIMEOUT;
    end else if (!cmd_ok) begin
      r = sraf_pkg::ST_CMD_FAIL;
    end else if (!sum_ok) begin
      r = sraf_pkg::ST_SUM_FAIL;
    end else begin
      r = sraf_pkg::ST_OK;
    end
    return r;
  endfunction

  function automatic logic [1:0] counter_of(input sraf_pkg::status_e s);
    logic [1:0] r;
    case (s)
      sraf_pkg::ST_TIMEOUT:  r = sraf_pkg::CntTimeout;
      sraf_pkg::ST_CMD_FAIL: r = sraf_pkg::CntCmdFail;
      sraf_pkg::ST_SUM_FAIL: r = sraf_pkg::CntSumFail;
      default:               r = sraf_pkg::CntOk;
    endcase
    return r;
  endfunction

  assign count_ok = (it_cnt_q != '0) && (it_cnt_q <= sraf_pkg::CntW'(sraf_pkg::MaxBytes));
  assign is_rd    = (it_mode_q == sraf_pkg::MODE_OPEN_RD);
  assign op_base  = is_rd ? (it_eep_q ? sraf_pkg::OpEepRead : sraf_pkg::OpRamRead)
                          : (it_eep_q ? sraf_pkg::OpEepWrite : sraf_pkg::OpRamWrite);
  assign open_cmd = op_base | ({3'b000, it_cnt_q} & sraf_pkg::CountMask);
  assign open_sum = open_cmd + it_addr_q[15:8] + it_addr_q[7:0];
  assign pos_inc  = pos_q + sraf_pkg::CntW'(1);
  assign rd_st    = judge(elapsed_q, timeout_q, first_q[0], sum_q == it_db_q);
  assign wr_st    = judge(elapsed_q, timeout_q, first_q[0], first_q == it_db_q);

  always_comb begin
    phase_d    = phase_q;
    len_d      = len_q;
    pos_d      = pos_q;
    sum_d      = sum_q;
    first_d    = first_q;
    rev_d      = rev_q;
    elapsed_d  = elapsed_q;
    plan_d     = plan_q;
    res_n_d    = res_n_q;
    st_d       = st_q;
    cmd_byte_d = cmd_byte_q;
    run        = 1'b0;
    buf_we     = 1'b0;
    buf_waddr  = pos_q[sraf_pkg::BufIdxW-1:0] - sraf_pkg::BufIdxW'(1);
    bump_en    = 1'b0;
    bump_idx   = sraf_pkg::CntOk;
    clr        = 1'b0;
    if (cmd_i.exec) begin
      case (sraf_pkg::mode_e'(it_mode_q))
        sraf_pkg::MODE_OPEN_RD, sraf_pkg::MODE_OPEN_WR: begin
          run = 1'b1;
          if (!count_ok) begin
            phase_d = sraf_pkg::PH_IDLE;
            plan_d  = sraf_pkg::PL_INVALID;
            res_n_d = sraf_pkg::CntW'(1);
            st_d    = sraf_pkg::ST_BAD_COUNT;
          end else begin
            len_d      = it_cnt_q;
            pos_d      = '0;
            sum_d      = open_sum;
            rev_d      = is_rd & it_swp_q;
            elapsed_d  = '0;
            cmd_byte_d = open_cmd;
            if (is_rd) begin
              plan_d  = sraf_pkg::PL_OPEN_RD;
              res_n_d = sraf_pkg::CntW'(4);
              phase_d = sraf_pkg::PH_RESP_READ;
            end else begin
              plan_d  = sraf_pkg::PL_OPEN_WR;
              res_n_d = sraf_pkg::CntW'(3);
              phase_d = sraf_pkg::PH_PAYLOAD;
            end
          end
        end
        sraf_pkg::MODE_PAYLOAD: begin
          if (phase_q == sraf_pkg::PH_PAYLOAD) begin
            run   = 1'b1;
            sum_d = sum_q + it_db_q;
            if (pos_inc >= len_q) begin
              plan_d  = sraf_pkg::PL_PAY_END;
              res_n_d = sraf_pkg::CntW'(2);
              phase_d = sraf_pkg::PH_RESP_WRITE;
              pos_d   = '0;
            end else begin
              plan_d  = sraf_pkg::PL_PAY_MID;
              res_n_d = sraf_pkg::CntW'(1);
              pos_d   = pos_inc;
            end
          end
        end
        sraf_pkg::MODE_RESP: begin
          if (phase_q == sraf_pkg::PH_RESP_READ) begin
            if (pos_q == '0) begin
              first_d = it_db_q;
              sum_d   = it_db_q;
              pos_d   = sraf_pkg::CntW'(1);
            end else if (pos_q <= len_q) begin
              buf_we = 1'b1;
              sum_d  = sum_q + it_db_q;
              pos_d  = pos_inc;
            end else begin
              run      = 1'b1;
              st_d     = rd_st;
              bump_en  = 1'b1;
              bump_idx = counter_of(rd_st);
              phase_d  = sraf_pkg::PH_IDLE;
              plan_d   = sraf_pkg::PL_FIN_RD;
              res_n_d  = (rd_st == sraf_pkg::ST_OK) ? len_q + sraf_pkg::CntW'(1)
                                                    : sraf_pkg::CntW'(1);
            end
          end else if (phase_q == sraf_pkg::PH_RESP_WRITE) begin
            if (pos_q == '0) begin
              first_d = it_db_q;
              pos_d   = sraf_pkg::CntW'(1);
            end else begin
              run      = 1'b1;
              st_d     = wr_st;
              bump_en  = 1'b1;
              bump_idx = counter_of(wr_st);
              phase_d  = sraf_pkg::PH_IDLE;
              plan_d   = sraf_pkg::PL_FIN_WR;
              res_n_d  = sraf_pkg::CntW'(1);
            end
          end
        end
        sraf_pkg::MODE_TICK: begin
          if (phase_q != sraf_pkg::PH_IDLE && elapsed_q != sraf_pkg::ElapsedMax) begin
            elapsed_d = elapsed_q + 16'd1;
          end
        end
        sraf_pkg::MODE_CLEAR: begin
          clr = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Result selection for the current position in the run.
  assign src_full  = rev_q ? (len_q - sraf_pkg::CntW'(1) - idx_q) : idx_q;
  assign src       = src_full[sraf_pkg::BufIdxW-1:0];
  assign emit_last = (idx_q == res_n_q - sraf_pkg::CntW'(1));

  always_comb begin
    e_kind = sraf_pkg::KIND_SEND;
    e_byte = 8'h00;
    e_st   = sraf_pkg::ST_OK;
    case (plan_q)
      sraf_pkg::PL_INVALID, sraf_pkg::PL_FIN_WR: begin
        e_kind = sraf_pkg::KIND_STATUS;
        e_st   = st_q;
      end
      sraf_pkg::PL_OPEN_RD: begin
        case (idx_q)
          5'd0:    e_byte = cmd_byte_q;
          5'd1:    e_byte = it_addr_q[15:8];
          5'd2:    e_byte = it_addr_q[7:0];
          default: e_byte = sum_q;
        endcase
      end
      sraf_pkg::PL_OPEN_WR: begin
        case (idx_q)
          5'd0:    e_byte = cmd_byte_q;
          5'd1:    e_byte = it_addr_q[15:8];
          default: e_byte = it_addr_q[7:0];
        endcase
      end
      sraf_pkg::PL_PAY_MID: begin
        e_byte = it_db_q;
      end
      sraf_pkg::PL_PAY_END: begin
        e_byte = (idx_q == '0) ? it_db_q : sum_q;
      end
      sraf_pkg::PL_FIN_RD: begin
        if (emit_last) begin
          e_kind = sraf_pkg::KIND_STATUS;
          e_st   = st_q;
        end else begin
          e_kind = sraf_pkg::KIND_DATA;
          e_byte = buf_q[src];
        end
      end
      default: begin
      end
    endcase
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      it_mode_q <= in_user_i;
      it_eep_q  <= in_data_i[0];
      it_cnt_q  <= in_data_i[5:1];
      it_addr_q <= in_data_i[21:6];
      it_swp_q  <= in_data_i[22];
      it_db_q   <= in_data_i[30:23];
    end
    if (buf_we) begin
      buf_q[buf_waddr] <= it_db_q;
    end
    if (cmd_i.emit) begin
      out_kind_q <= e_kind;
      out_byte_q <= e_byte;
      out_st_q   <= e_st;
      out_last_q <= emit_last;
      for (int i = 0; i < 4; i++) begin
        out_cnt_q[i] <= cnt_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= sraf_pkg::TimeoutReset;
      phase_q     <= sraf_pkg::PH_IDLE;
      len_q       <= '0;
      pos_q       <= '0;
      sum_q       <= '0;
      first_q     <= '0;
      rev_q       <= 1'b0;
      elapsed_q   <= '0;
      plan_q      <= sraf_pkg::PL_INVALID;
      res_n_q     <= '0;
      idx_q       <= '0;
      st_q        <= sraf_pkg::ST_OK;
      cmd_byte_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        timeout_q <= cfg_data_i;
      end
      phase_q    <= phase_d;
      len_q      <= len_d;
      pos_q      <= pos_d;
      sum_q      <= sum_d;
      first_q    <= first_d;
      rev_q      <= rev_d;
      elapsed_q  <= elapsed_d;
      plan_q     <= plan_d;
      res_n_q    <= res_n_d;
      st_q       <= st_d;
      cmd_byte_q <= cmd_byte_d;
      if (run) begin
        idx_q <= '0;
      end else if (cmd_i.emit) begin
        idx_q <= idx_q + sraf_pkg::CntW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      for (int i = 0; i < 4; i++) begin
        if (clr) begin
          cnt_q[i] <= '0;
        end else if (bump_en && bump_idx == 2'(i) && cnt_q[i] != sraf_pkg::CounterMax) begin
          cnt_q[i] <= cnt_q[i] + 32'd1;
        end
      end
    end
  end

  assign stat_o.has_results = run;
  assign stat_o.out_free    = !out_valid_q || out_ready_i;
  assign stat_o.emit_last   = emit_last;

  assign out_valid_o = out_valid_q;
  assign out_user_o  = out_kind_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {5'b00000, out_cnt_q[3], out_cnt_q[2], out_cnt_q[1], out_cnt_q[0],
                        out_st_q, out_byte_q};

endmodule

`default_nettype wire

// ===== design/sensor_register_access_framer_top.sv =====
// Top level of the sensor register access framer: controller plus datapath.
// Depends on sraf_pkg, sraf_ctrl and sraf_datapath.
//
// Channel   Dir  Handshake                  Content
// s_axis    in   s_axis_tvalid/tready       request, payload, response byte, tick, clear
// m_axis    out  m_axis_tvalid/tready       bytes to send, read data, status
// cfg       in   cfg_valid_i/cfg_ready_o    timeout_ms register write
//
// An item is accepted in CS_IDLE and executed in CS_EXEC; CS_EMIT then moves
// one result per cycle into the output register while it is free; a full
// 16-byte read finish gives 17 results, which leave through the single output
// register one by one; items without results return from CS_EXEC to CS_IDLE.
// Reset clears the protocol state, the counters and the output valid; the
// timeout register returns to 1000. A stalled output holds its result, and the
// input is not taken again until the whole run has entered the output register.
`default_nettype none

module sensor_register_access_framer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input item. tuser: mode[2:0].
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: to_eeprom[0], byte_count[5:1], mem_address[21:6], swap_order[22],
  // data_byte[30:23], zero[31].
  input  logic [sraf_pkg::InTdataW-1:0]       s_axis_tdata,
  input  logic [2:0]                          s_axis_tuser,
  // Result item. tuser: kind[1:0]. tlast: last.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: out_byte[7:0], status[10:8], ok_count[42:11], timeout_count[74:43],
  // command_fail_count[106:75], checksum_fail_count[138:107], zero[143:139].
  output logic [sraf_pkg::OutTdataW-1:0]      m_axis_tdata,
  output logic [1:0]                          m_axis_tuser,
  output logic                                m_axis_tlast,
  // Timeout register write.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [15:0]                         cfg_data_i
);

  sraf_pkg::dp_cmd_t  cmd;
  sraf_pkg::dp_stat_t stat;

  // The timeout register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  sraf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sraf_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== design/sraf_checker.sv =====
// Port-level checker for the sensor register access framer, bound to the top.
// Depends on sraf_pkg and sensor_register_access_framer_top_assert.svh.
`default_nettype none
`include "sensor_register_access_framer_top_assert.svh"

module sraf_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [sraf_pkg::OutTdataW-1:0]      m_axis_tdata,
  input logic [1:0]                          m_axis_tuser,
  input logic                                m_axis_tlast
);

  // A stalled result keeps its contents.
  property p_out_hold;
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast);
  endproperty

  // A status result closes its run and carries no byte.
  property p_status_last;
    m_axis_tvalid && m_axis_tuser == sraf_pkg::KIND_STATUS
      |-> m_axis_tlast && m_axis_tdata[7:0] == 8'h00;
  endproperty

  // Byte results carry a zero status code.
  property p_byte_status;
    m_axis_tvalid && m_axis_tuser != sraf_pkg::KIND_STATUS |-> m_axis_tdata[10:8] == 3'd0;
  endproperty

  `SRAF_ASSERT(a_out_hold, p_out_hold, "result changed while stalled")
  `SRAF_ASSERT(a_status_last, p_status_last, "status result not last or byte not zero")
  `SRAF_ASSERT(a_byte_status, p_byte_status, "byte result with nonzero status")

  // Reset empties the output register.
  `SRAF_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind sensor_register_access_framer_top sraf_checker u_sraf_checker (.*);

`default_nettype wire
